### sv/lapl_pkg.sv
// Shared types, register indexes and the per-channel Laplacian kernel
// for the 3x3 RGB edge detector. No dependencies.
package lapl_pkg;

  localparam int WidthBits  = 6;
  localparam int HeightBits = 12;
  localparam int CfgBits    = 12;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    pixel_t mid;
    pixel_t up;
  } line_pair_t;

  function automatic logic [7:0] lap_channel(logic [7:0] c, logic [7:0][7:0] nb);
    logic [10:0]        s;
    logic signed [11:0] d;
    s = '0;
    for (int k = 0; k < 8; k++) begin
      s = s + 11'(nb[k]);
    end
    d = $signed({1'b0, c, 3'b000}) - $signed({1'b0, s});
    if (d < 0) begin
      return 8'd0;
    end else if (d > 12'sd255) begin
      return 8'd255;
    end
    return d[7:0];
  endfunction

  function automatic pixel_t lap_pixel(pixel_t [8:0] w);
    pixel_t p;
    p.red   = lap_channel(w[4].red,   {w[8].red,   w[7].red,   w[6].red,   w[5].red,
                                       w[3].red,   w[2].red,   w[1].red,   w[0].red});
    p.green = lap_channel(w[4].green, {w[8].green, w[7].green, w[6].green, w[5].green,
                                       w[3].green, w[2].green, w[1].green, w[0].green});
    p.blue  = lap_channel(w[4].blue,  {w[8].blue,  w[7].blue,  w[6].blue,  w[5].blue,
                                       w[3].blue,  w[2].blue,  w[1].blue,  w[0].blue});
    return p;
  endfunction

endpackage

### sv/laplacian_edge_3x3_rgb.sv
// Top level of the streaming 3x3 Laplacian edge detector for RGB pixels.
// Depends on lapl_pkg, lapl_linebuf and lapl_window.
//
// Pixels of a frame enter in raster order on the in_ stream, one word per
// pixel. Each word from the second line onward (after the first pixel of
// that line) gives one result word on the out_ stream for the pixel one line
// plus one pixel earlier: eight times the centre minus its eight neighbors,
// clamped to 0..255 per channel, and zero on the frame border. The last
// pixel of a frame gives image_width + 2 words, ending with the bottom-right
// pixel; out_tlast marks the final word caused by each input word.
// Throughput is one pixel per cycle while the output is not stalled and no
// flush runs, set by the single line buffer port pair and the window update.
// A pixel is registered in the input stage, and its result in the output register.
// During the end-of-frame flush of image_width + 1 words in_tready stays low.
// A stall on out_tready holds the output register; one more pixel is taken
// into the input stage, then in_tready falls. Reset clears the counters and
// sets width and height to 32. A configuration write restarts the frame.
module laplacian_edge_3x3_rgb #(
  parameter int MAX_LINE_PIXELS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue_in [23:16], green_in [15:8], red_in [7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // blue_out [23:16], green_out [15:8], red_out [7:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  lapl_pkg::cfg_reg_t cfg_addr,
  input  logic [lapl_pkg::CfgBits-1:0] cfg_wdata
);
  import lapl_pkg::*;

  localparam int AW = $clog2(MAX_LINE_PIXELS);
  localparam int FW = $clog2(MAX_LINE_PIXELS + 2);
  localparam logic [WidthBits-1:0] MaxW = WidthBits'(MAX_LINE_PIXELS);

  logic [WidthBits-1:0]  wcfg_r;
  logic [HeightBits-1:0] hcfg_r;
  logic [AW-1:0]         ic_r, oc_r;
  logic [HeightBits-1:0] ir_r, or_r;
  logic                  s1_v_r, s1_emit_r, s1_last_r;
  pixel_t                s1_px_r;
  logic [AW-1:0]         s1_col_r;
  logic [FW-1:0]         flush_cnt_r;
  logic                  out_v_r, out_last_r;
  pixel_t                out_px_r;

  logic [WidthBits-1:0]  w_eff, w_m1, w_m2, ic_ext, oc_ext;
  logic [HeightBits-1:0] h_eff, h_m1, h_m2;
  logic in_acc, out_free, flush_act, s1_fire, flush_emit, in_last, in_emit, inner;
  line_pair_t rd_q;
  pixel_t     edge_px;

  always_comb begin
    if (wcfg_r < WidthBits'(3)) begin
      w_eff = WidthBits'(3);
    end else if (wcfg_r > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = wcfg_r;
    end
    h_eff = (hcfg_r < HeightBits'(3)) ? HeightBits'(3) : hcfg_r;
  end

  assign w_m1   = w_eff - WidthBits'(1);
  assign w_m2   = w_eff - WidthBits'(2);
  assign h_m1   = h_eff - HeightBits'(1);
  assign h_m2   = h_eff - HeightBits'(2);
  assign ic_ext = WidthBits'(ic_r);
  assign oc_ext = WidthBits'(oc_r);

  assign out_free   = !out_v_r || out_tready;
  assign flush_act  = (flush_cnt_r != '0);
  assign s1_fire    = s1_v_r && !flush_act && (!s1_emit_r || out_free);
  assign flush_emit = flush_act && out_free;
  assign in_tready  = rst_n && !flush_act && (!s1_v_r || s1_fire);
  assign in_acc     = in_tvalid && in_tready;

  assign in_last = (ir_r >= h_m1) && (ic_ext >= w_m1);
  assign in_emit = (ir_r >= HeightBits'(2)) || ((ir_r == HeightBits'(1)) && (ic_r != '0));
  assign inner   = (or_r != '0) && (or_r <= h_m2) && (oc_r != '0) && (oc_ext <= w_m2);

  lapl_linebuf #(
    .DEPTH (MAX_LINE_PIXELS),
    .AW    (AW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (ic_r),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data ('{mid: s1_px_r, up: rd_q.mid}),
    .rd_q    (rd_q)
  );

  lapl_window u_window (
    .clk      (clk),
    .shift_en (s1_fire),
    .up       (rd_q.up),
    .mid      (rd_q.mid),
    .px       (s1_px_r),
    .edge_px  (edge_px)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcfg_r      <= WidthBits'(32);
      hcfg_r      <= HeightBits'(32);
      ic_r        <= '0;
      ir_r        <= '0;
      oc_r        <= '0;
      or_r        <= '0;
      s1_v_r      <= 1'b0;
      flush_cnt_r <= '0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_WIDTH:  wcfg_r <= cfg_wdata[WidthBits-1:0];
          REG_HEIGHT: hcfg_r <= cfg_wdata[HeightBits-1:0];
          default: ;
        endcase
        ic_r <= '0;
        ir_r <= '0;
        oc_r <= '0;
        or_r <= '0;
      end else begin
        if (in_acc) begin
          if (in_last) begin
            ic_r <= '0;
            ir_r <= '0;
          end else if (ic_ext + WidthBits'(1) >= w_eff) begin
            ic_r <= '0;
            ir_r <= ir_r + HeightBits'(1);
          end else begin
            ic_r <= ic_r + AW'(1);
          end
        end
        if (s1_fire && s1_emit_r) begin
          if (s1_last_r) begin
            oc_r <= '0;
            or_r <= '0;
          end else if (oc_ext + WidthBits'(1) >= w_eff) begin
            oc_r <= '0;
            or_r <= or_r + HeightBits'(1);
          end else begin
            oc_r <= oc_r + AW'(1);
          end
        end
      end

      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end

      if (s1_fire && s1_last_r) begin
        flush_cnt_r <= FW'({1'b0, w_eff} + 7'd1);
      end else if (flush_emit) begin
        flush_cnt_r <= flush_cnt_r - FW'(1);
      end

      if ((s1_fire && s1_emit_r) || flush_emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r   <= pixel_t'(in_tdata);
      s1_col_r  <= ic_r;
      s1_emit_r <= in_emit;
      s1_last_r <= in_last;
    end
    if (flush_emit) begin
      out_px_r   <= '0;
      out_last_r <= (flush_cnt_r == FW'(1));
    end else if (s1_fire && s1_emit_r) begin
      out_px_r   <= inner ? edge_px : '0;
      out_last_r <= !s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_px_r;
  assign out_tlast  = out_last_r;

endmodule

### sv/lapl_linebuf.sv
// Two-line pixel buffer: one memory word per column holds the upper and
// middle lines. Registered read, one write per cycle. Uses lapl_pkg.
module lapl_linebuf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  lapl_pkg::line_pair_t   wr_data,
  output lapl_pkg::line_pair_t   rd_q
);
  import lapl_pkg::*;

  line_pair_t mem [DEPTH];
  line_pair_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_q = rd_q_r;

endmodule

### sv/lapl_window.sv
// 3x3 pixel window and the Laplacian kernel applied to the shifted window.
// Uses lapl_pkg for the pixel type and the kernel function.
module lapl_window (
  input  logic             clk,
  input  logic             shift_en,
  input  lapl_pkg::pixel_t up,
  input  lapl_pkg::pixel_t mid,
  input  lapl_pkg::pixel_t px,
  output lapl_pkg::pixel_t edge_px
);
  import lapl_pkg::*;

  pixel_t [8:0] win_r;
  pixel_t [8:0] win_nxt;

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = px;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r <= win_nxt;
    end
  end

  assign edge_px = lap_pixel(win_nxt);

endmodule

### sim/laplacian_edge_3x3_rgb_tb.sv
// Self-checking testbench for the streaming 3x3 Laplacian RGB edge detector.
// Predicts every result word in-house and checks it against out_tdata/out_tlast.
// Depends on lapl_pkg and laplacian_edge_3x3_rgb.
module laplacian_edge_3x3_rgb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lapl_pkg::*;

  localparam int MaxLine = 32;

  typedef struct {
    pixel_t px;
    logic   last;
  } edge_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_addr = REG_WIDTH;
  logic [CfgBits-1:0] cfg_wdata = '0;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int errors = 0;

  // Predictor state.
  pixel_t           upper_line [MaxLine];
  pixel_t           middle_line [MaxLine];
  pixel_t           window_px [9];
  int               in_col = 0;
  int               in_row = 0;
  int               out_col = 0;
  int               out_row = 0;
  logic [WidthBits-1:0]  width_reg = 6'd32;
  logic [HeightBits-1:0] height_reg = 12'd32;
  edge_word_t       pending_edges [$];

  laplacian_edge_3x3_rgb uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("laplacian_edge_3x3_rgb verification failed");
    $finish;
  end

  function automatic int cur_width();
    if (width_reg < 3) begin
      return 3;
    end
    if (width_reg > MaxLine) begin
      return MaxLine;
    end
    return int'(width_reg);
  endfunction

  function automatic int cur_height();
    return (height_reg < 3) ? 3 : int'(height_reg);
  endfunction

  function automatic int channel_of(pixel_t p, int c);
    case (c)
      0: begin
        return int'(p.red);
      end
      1: begin
        return int'(p.green);
      end
      default: begin
        return int'(p.blue);
      end
    endcase
  endfunction

  function automatic logic [7:0] laplace_channel(int c);
    int acc;
    acc = 0;
    for (int k = 0; k < 9; k++) begin
      if (k == 4) begin
        acc += 8 * channel_of(window_px[k], c);
      end else begin
        acc -= channel_of(window_px[k], c);
      end
    end
    if (acc < 0) begin
      return 8'd0;
    end
    if (acc > 255) begin
      return 8'd255;
    end
    return acc[7:0];
  endfunction

  function automatic edge_word_t next_edge(int w, int h);
    edge_word_t r;
    bit interior;
    interior = out_row >= 1 && out_row <= h - 2 && out_col >= 1 && out_col <= w - 2;
    r.px   = '0;
    r.last = 1'b0;
    if (interior) begin
      r.px.red   = laplace_channel(0);
      r.px.green = laplace_channel(1);
      r.px.blue  = laplace_channel(2);
    end
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    return r;
  endfunction

  task automatic predict_pixel(input pixel_t p);
    int w;
    int h;
    int ic;
    int ir;
    int n;
    bit held_valid;
    edge_word_t held;
    pixel_t up;
    pixel_t mid;
    w = cur_width();
    h = cur_height();
    ic = in_col;
    ir = in_row;
    n = 0;
    held_valid = 0;
    up = upper_line[ic];
    mid = middle_line[ic];
    upper_line[ic] = mid;
    middle_line[ic] = p;
    for (int r = 0; r < 3; r++) begin
      window_px[r * 3]     = window_px[r * 3 + 1];
      window_px[r * 3 + 1] = window_px[r * 3 + 2];
    end
    window_px[2] = up;
    window_px[5] = mid;
    window_px[8] = p;
    if (ir >= 2 || (ir == 1 && ic >= 1)) begin
      held = next_edge(w, h);
      held_valid = 1;
      n++;
    end
    if (ir >= h - 1 && ic >= w - 1) begin
      // The last pixel of a frame flushes the remaining border words.
      while (out_row < h && n < 64) begin
        if (held_valid) begin
          pending_edges.push_back(held);
        end
        held = next_edge(w, h);
        held_valid = 1;
        n++;
      end
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      in_col = ic + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row = ir + 1;
      end
    end
    if (held_valid) begin
      held.last = 1'b1;
      pending_edges.push_back(held);
    end
  endtask

  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do begin
      @(posedge clk);
    end while (!in_tready);
    predict_pixel(p);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_edges.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic settle();
    wait_drained();
    repeat (MaxLine + 8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgBits-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_WIDTH) begin
      width_reg = val[WidthBits-1:0];
    end else begin
      height_reg = val[HeightBits-1:0];
    end
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    case ($urandom_range(0, 3))
      0: begin
        p = pixel_t'(24'($urandom));
      end
      1: begin
        p.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        p.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        p.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      2: begin
        p.red   = 8'($urandom_range(100, 130));
        p.green = 8'($urandom_range(100, 130));
        p.blue  = 8'($urandom_range(100, 130));
      end
      default: begin
        p.red   = 8'($urandom_range(0, 40));
        p.green = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 40));
        p.blue  = 8'($urandom_range(0, 40));
      end
    endcase
    return p;
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin : check_results
    edge_word_t want;
    pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = pixel_t'(out_tdata);
      if (pending_edges.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        want = pending_edges.pop_front();
        if (got.red !== want.px.red) begin
          $error("red_out: expected %0d, got %0d", want.px.red, got.red);
          errors++;
        end
        if (got.green !== want.px.green) begin
          $error("green_out: expected %0d, got %0d", want.px.green, got.green);
          errors++;
        end
        if (got.blue !== want.px.blue) begin
          $error("blue_out: expected %0d, got %0d", want.px.blue, got.blue);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Smallest frames with a single interior pixel: clamping at both ends,
  // flat areas and a mid-range result, with a full drain in mid-frame.
  task automatic test_small_frames();
    pixel_t p;
    settle();
    write_reg(REG_WIDTH, 12'd3);
    write_reg(REG_HEIGHT, 12'd3);
    for (int i = 0; i < 9; i++) begin
      p.red   = (i == 4) ? 8'd255 : 8'd0;
      p.green = (i == 4) ? 8'd0 : 8'd255;
      p.blue  = (i == 4) ? 8'd40 : 8'd10;
      send_pixel(p);
    end
    for (int i = 0; i < 9; i++) begin
      if (i == 4) begin
        wait_drained();
      end
      p.red   = (i == 4) ? 8'd32 : 8'd31;
      p.green = 8'd255;
      p.blue  = (i == 4) ? 8'h55 : 8'h50;
      send_pixel(p);
    end
  endtask

  // Register values below the minimum act as the minimum; unused upper
  // bits of the write data are ignored.
  task automatic test_register_clamping();
    settle();
    write_reg(REG_WIDTH, 12'hFC1);
    write_reg(REG_HEIGHT, 12'd2);
    for (int i = 0; i < 9; i++) begin
      send_pixel(rand_pixel());
    end
    settle();
    write_reg(REG_WIDTH, 12'd0);
    write_reg(REG_HEIGHT, 12'd0);
    for (int i = 0; i < 9; i++) begin
      send_pixel(rand_pixel());
    end
  endtask

  // Widest lines and tallest frames; tall frames are cut short and restarted.
  task automatic test_register_extremes();
    settle();
    write_reg(REG_WIDTH, 12'd63);
    write_reg(REG_HEIGHT, 12'd1);
    for (int i = 0; i < MaxLine * 3; i++) begin
      send_pixel(rand_pixel());
    end
    settle();
    write_reg(REG_WIDTH, 12'd62);
    write_reg(REG_HEIGHT, 12'd4095);
    for (int i = 0; i < 80; i++) begin
      send_pixel(rand_pixel());
    end
    settle();
    write_reg(REG_WIDTH, 12'hFC3);
    for (int i = 0; i < 40; i++) begin
      send_pixel(rand_pixel());
    end
  endtask

  task automatic test_random_frames(input int n_items);
    int sent;
    int w;
    int h;
    int total;
    int cut;
    bit partial;
    bit restart_due;
    sent = 0;
    restart_due = 1;
    while (sent < n_items) begin
      if (restart_due || $urandom_range(0, 3) != 0) begin
        settle();
        case ($urandom_range(0, 9))
          0: w = $urandom_range(0, 2);
          1: w = $urandom_range(32, 63);
          default: w = $urandom_range(3, 10);
        endcase
        case ($urandom_range(0, 9))
          0: h = $urandom_range(0, 2);
          1: h = $urandom_range(100, 4095);
          default: h = $urandom_range(3, 6);
        endcase
        write_reg(REG_WIDTH, {6'($urandom), 6'(w)});
        write_reg(REG_HEIGHT, 12'(h));
      end
      total = cur_width() * cur_height();
      partial = (total > 160) || ($urandom_range(0, 7) == 0);
      cut = partial ? $urandom_range(1, (total - 1 < 120) ? total - 1 : 120) : total;
      for (int i = 0; i < cut && sent < n_items; i++) begin
        if ($urandom_range(0, 199) == 0) begin
          wait_drained();
        end
        send_pixel(rand_pixel());
        sent++;
      end
      restart_due = partial;
    end
  endtask

  initial begin
    for (int i = 0; i < MaxLine; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) begin
      window_px[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 33;
    sink_idle_pct = 46;
    test_small_frames();
    test_register_clamping();
    test_register_extremes();
    test_random_frames(76);

    src_idle_pct = 46;
    sink_idle_pct = 33;
    test_random_frames(76);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_frames(76);

    settle();
    if (pending_edges.size() != 0) begin
      $error("%0d expected result words never arrived", pending_edges.size());
      errors++;
    end
    if (errors == 0) begin
      $display("laplacian_edge_3x3_rgb verification clean");
    end else begin
      $display("laplacian_edge_3x3_rgb verification failed");
    end
    $finish;
  end

endmodule
